// ===== rtl/core/rmsd_pkg.sv =====
`timescale 1ns / 1ps

package rmsd_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int COUNT_BITS  = 32;

  localparam int DATA_W      = 32;
  localparam int STD_W       = 31;
  localparam int VAR_W       = 64;
  localparam int ALU_W       = 35;
  localparam int EXT_SHIFT   = DATA_W - SAMPLE_BITS;

  localparam int DIV1_STEPS  = DATA_W + 1;
  localparam int DIV2_STEPS  = VAR_W;
  localparam int SQRT_STEPS  = VAR_W / 2;
  localparam int ITER_W      = $clog2(DIV2_STEPS);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    CMD_ACC   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV1,
    S_MEAN,
    S_DNEW,
    S_MUL,
    S_VSUB,
    S_DIV2,
    S_VUPD,
    S_SQRT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic div_step;
    logic sqrt_step;
    logic mean_upd;
    logic dnew;
    logic mul;
    logic vsub;
    logic vupd;
    logic load_out;
  } ctl_t;

endpackage

// ===== rtl/core/running_mean_std_dev_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat fields (tdata / tuser, low bit first)
// s_axis    in   tdata: sample[31:0]      tuser: cmd (0 accumulate, 1 clear)
// m_axis    out  tdata: mean[31:0], std_dev[62:32], zero pad [63]
//
// A sample passes from its accept to the earliest next accept through 33
// divide steps for the mean, 64 for the variance and 32 square-root steps, all
// through one shared compare-subtract unit, plus setup and one 32x32 multiply.
// A clear produces no beat. Reset zeroes count, mean and variance. A finished
// result waits in the output register; the core holds the next result until
// that beat is taken.

module running_mean_std_dev_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rmsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // sample
  input  logic                               s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rmsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // mean, std_dev, pad
);
  import rmsd_pkg::*;

  ctl_t               ctl;
  logic [DATA_W-1:0]  mean;
  logic [STD_W-1:0]   std_dev;

  rmsd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctl_o       (ctl)
  );

  rmsd_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sample_i  (s_axis_tdata[DATA_W-1:0]),
    .mean_o    (mean),
    .std_dev_o (std_dev)
  );

  assign m_axis_tdata = OUT_TDATA_W'({std_dev, mean});

endmodule

// ===== rtl/core/rmsd_seq.sv =====
`timescale 1ns / 1ps

module rmsd_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output rmsd_pkg::ctl_t ctl_o
);
  import rmsd_pkg::*;

  state_e              state_q, state_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and step counter
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_cmd_i == CMD_ACC)) begin
          state_d = S_DIV1;
          iter_d  = ITER_W'(DIV1_STEPS - 1);
        end
      end
      S_DIV1: begin
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_MEAN;
      end
      S_MEAN: state_d = S_DNEW;
      S_DNEW: state_d = S_MUL;
      S_MUL:  state_d = S_VSUB;
      S_VSUB: begin
        state_d = S_DIV2;
        iter_d  = ITER_W'(DIV2_STEPS - 1);
      end
      S_DIV2: begin
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_VUPD;
      end
      S_VUPD: begin
        state_d = S_SQRT;
        iter_d  = ITER_W'(SQRT_STEPS - 1);
      end
      S_SQRT: begin
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.start = in_valid_i && (in_cmd_i == CMD_ACC);
        ctl_o.clear = in_valid_i && (in_cmd_i == CMD_CLEAR);
      end
      S_DIV1:  ctl_o.div_step  = 1'b1;
      S_MEAN:  ctl_o.mean_upd  = 1'b1;
      S_DNEW:  ctl_o.dnew      = 1'b1;
      S_MUL:   ctl_o.mul       = 1'b1;
      S_VSUB:  ctl_o.vsub      = 1'b1;
      S_DIV2:  ctl_o.div_step  = 1'b1;
      S_VUPD:  ctl_o.vupd      = 1'b1;
      S_SQRT:  ctl_o.sqrt_step = 1'b1;
      S_DONE:  ctl_o.load_out  = !out_valid_q || out_ready_i;
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_div1_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV1) |-> (iter_q <= ITER_W'(DIV1_STEPS - 1)))
    else $error("divide step count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_cmd_i == CMD_CLEAR)) |=> (state_q == S_IDLE))
    else $error("clear left idle");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_cmd_i == CMD_ACC)) |=> (state_q == S_DIV1))
    else $error("sample did not start divide");

endmodule

// ===== rtl/core/rmsd_dp.sv =====
`timescale 1ns / 1ps

module rmsd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmsd_pkg::ctl_t                ctl_i,
  input  logic [rmsd_pkg::DATA_W-1:0]   sample_i,
  output logic [rmsd_pkg::DATA_W-1:0]   mean_o,
  output logic [rmsd_pkg::STD_W-1:0]    std_dev_o
);
  import rmsd_pkg::*;

  // model state
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [DATA_W-1:0]     mean_q, mean_d;
  logic [VAR_W-1:0]      var_q, var_d;

  // work registers
  logic [DATA_W-1:0]     x_q, x_d;
  logic [DATA_W-1:0]     dmag_q, dmag_d;
  logic [DATA_W-1:0]     bmag_q, bmag_d;
  logic [VAR_W-1:0]      p_q, p_d;
  logic [VAR_W-1:0]      acc_q, acc_d;
  logic [ALU_W-1:0]      rem_q, rem_d;
  logic [DATA_W-1:0]     root_q, root_d;
  logic                  neg_q, neg_d;
  logic [DATA_W-1:0]     mean_out_q, mean_out_d;
  logic [STD_W-1:0]      std_out_q, std_out_d;

  // shared compare-subtract unit
  logic [ALU_W-1:0]      alu_a, alu_b;
  logic [ALU_W:0]        alu_diff;
  logic                  alu_ge;

  logic [DATA_W-1:0]     x_ext;
  logic [DATA_W:0]       dold, dold_mag, dnew, dnew_mag;
  logic [DATA_W:0]       quo;
  logic [DATA_W+1:0]     mean_sum;
  logic                  p_ge;
  logic [VAR_W-1:0]      var_new;

  always_comb begin
    if (ctl_i.sqrt_step) begin
      alu_a = {rem_q[ALU_W-3:0], acc_q[VAR_W-1:VAR_W-2]};
      alu_b = ALU_W'({root_q, 2'b01});
    end else begin
      alu_a = {rem_q[ALU_W-2:0], acc_q[VAR_W-1]};
      alu_b = ALU_W'(count_q);
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[ALU_W];
  end

  assign x_ext    = DATA_W'($signed(sample_i << EXT_SHIFT) >>> EXT_SHIFT);
  assign dold     = {x_ext[DATA_W-1], x_ext} - {mean_q[DATA_W-1], mean_q};
  assign dold_mag = dold[DATA_W] ? (~dold + 1'b1) : dold;
  assign dnew     = {x_q[DATA_W-1], x_q} - {mean_q[DATA_W-1], mean_q};
  assign dnew_mag = dnew[DATA_W] ? (~dnew + 1'b1) : dnew;
  assign quo      = acc_q[DATA_W:0];
  assign mean_sum = {{2{mean_q[DATA_W-1]}}, mean_q}
                  + (neg_q ? (~{1'b0, quo} + 1'b1) : {1'b0, quo});
  assign p_ge     = p_q >= var_q;
  assign var_new  = neg_q ? (var_q - acc_q) : (var_q + acc_q);

  always_comb begin
    count_d    = count_q;
    mean_d     = mean_q;
    var_d      = var_q;
    x_d        = x_q;
    dmag_d     = dmag_q;
    bmag_d     = bmag_q;
    p_d        = p_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    root_d     = root_q;
    neg_d      = neg_q;
    mean_out_d = mean_out_q;
    std_out_d  = std_out_q;

    if (ctl_i.clear) begin
      count_d = '0;
      mean_d  = '0;
      var_d   = '0;
    end
    if (ctl_i.start) begin
      x_d     = x_ext;
      count_d = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
      neg_d   = dold[DATA_W];
      dmag_d  = dold_mag[DATA_W-1:0];
      acc_d   = {dold_mag, {(VAR_W - DATA_W - 1){1'b0}}};
      rem_d   = '0;
    end
    if (ctl_i.div_step) begin
      rem_d = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
      acc_d = {acc_q[VAR_W-2:0], alu_ge};
    end
    if (ctl_i.mean_upd) begin
      mean_d = mean_sum[DATA_W-1:0];
    end
    if (ctl_i.dnew) begin
      bmag_d = dnew_mag[DATA_W-1:0];
    end
    if (ctl_i.mul) begin
      p_d = VAR_W'(dmag_q) * VAR_W'(bmag_q);
    end
    if (ctl_i.vsub) begin
      acc_d = p_ge ? (p_q - var_q) : (var_q - p_q);
      neg_d = !p_ge;
      rem_d = '0;
    end
    if (ctl_i.vupd) begin
      var_d  = var_new;
      acc_d  = var_new;
      rem_d  = '0;
      root_d = '0;
    end
    if (ctl_i.sqrt_step) begin
      rem_d  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
      acc_d  = {acc_q[VAR_W-3:0], 2'b00};
      root_d = {root_q[DATA_W-2:0], alu_ge};
    end
    if (ctl_i.load_out) begin
      mean_out_d = mean_q;
      std_out_d  = root_q[DATA_W-1] ? STD_MAX : root_q[STD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mean_q  <= '0;
      var_q   <= '0;
    end else begin
      count_q <= count_d;
      mean_q  <= mean_d;
      var_q   <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    dmag_q     <= dmag_d;
    bmag_q     <= bmag_d;
    p_q        <= p_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    neg_q      <= neg_d;
    mean_out_q <= mean_out_d;
    std_out_q  <= std_out_d;
  end

  assign mean_o    = mean_out_q;
  assign std_dev_o = std_out_q;

endmodule

// ===== tb/tb_running_mean_std_dev_core.sv =====
`timescale 1ns / 1ps

module tb_running_mean_std_dev_core;

  import rmsd_pkg::*;

  localparam int ITEM_TARGET    = 1900;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_BEAT   = 40;
  localparam int CALM_TAIL      = 150;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct {
    cmd_e              cmd;
    logic [DATA_W-1:0] sample;
    bit                pause_first;
  } sample_beat_t;

  typedef struct {
    logic [DATA_W-1:0] mean;
    logic [STD_W-1:0]  std_dev;
  } stats_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  running_mean_std_dev_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // sample
    .s_axis_tuser (s_axis_tuser),   // cmd
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // mean, std_dev, pad
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  sample_beat_t pending_q[$];
  stats_t       stats_q[$];

  // running statistics as the core should hold them
  logic [COUNT_BITS-1:0]    stat_count = '0;
  logic signed [DATA_W-1:0] stat_mean  = '0;
  logic [VAR_W-1:0]         stat_var   = '0;

  int  err_count    = 0;
  int  idle_cycles  = 0;
  int  in_beats     = 0;
  int  out_beats    = 0;
  int  in_idle_pct  = 0;
  int  out_idle_pct = 0;
  int  in_gap       = 0;
  int  out_gap      = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  gap_armed    = 1'b0;
  bit  in_fire      = 1'b0;
  bit  calm         = 1'b0;

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  function automatic stats_t welford_update(input logic [DATA_W-1:0] raw);
    logic signed [DATA_W-1:0] xs;
    longint                   x;
    longint                   n;
    longint                   d_old;
    longint                   d_new;
    longint                   m_new;
    logic [VAR_W-1:0]         ua;
    logic [VAR_W-1:0]         ub;
    logic [VAR_W-1:0]         prod;
    logic [VAR_W-1:0]         nu;
    logic [VAR_W-1:0]         root;
    logic [VAR_W-1:0]         trial;
    stats_t                   res;
    xs = $signed(raw << EXT_SHIFT) >>> EXT_SHIFT;
    x  = longint'(xs);
    if (stat_count != COUNT_MAX) begin
      stat_count = stat_count + 1'b1;
    end
    n     = longint'(stat_count);
    d_old = x - longint'(stat_mean);
    m_new = longint'(stat_mean) + d_old / n;
    d_new = x - m_new;
    stat_mean = m_new[DATA_W-1:0];
    ua   = (d_old < 0) ? -d_old : d_old;
    ub   = (d_new < 0) ? -d_new : d_new;
    prod = ua * ub;
    nu   = n;
    if (prod >= stat_var) begin
      stat_var = stat_var + (prod - stat_var) / nu;
    end else begin
      stat_var = stat_var - (stat_var - prod) / nu;
    end
    // bitwise floor sqrt, root < 2^32 so trial^2 fits 64 bits
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= stat_var) begin
        root = trial;
      end
    end
    res.mean    = stat_mean;
    res.std_dev = (root > VAR_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
    return res;
  endfunction

  // check, predict, watchdog
  always @(posedge clk_i) begin
    stats_t exp_res;
    stats_t got_res;
    bit     progress;
    progress = 1'b0;
    in_fire  = 1'b0;
    if (m_axis_tvalid && m_axis_tready) begin
      progress = 1'b1;
      out_beats++;
      if (out_beats % 150 == 0) begin
        out_idle_pct = pick_idle_pct();
      end
      got_res.mean    = m_axis_tdata[DATA_W-1:0];
      got_res.std_dev = m_axis_tdata[DATA_W+STD_W-1:DATA_W];
      if (stats_q.size() == 0) begin
        $error("unexpected result beat: mean %h std_dev %h", got_res.mean, got_res.std_dev);
        err_count++;
      end else begin
        exp_res = stats_q.pop_front();
        if (got_res.mean !== exp_res.mean) begin
          $error("mean: expected %h, actual %h", exp_res.mean, got_res.mean);
          err_count++;
        end
        if (got_res.std_dev !== exp_res.std_dev) begin
          $error("std_dev: expected %h, actual %h", exp_res.std_dev, got_res.std_dev);
          err_count++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      progress = 1'b1;
      in_fire  = 1'b1;
      in_beats++;
      if (in_beats % 150 == 0) begin
        in_idle_pct = pick_idle_pct();
      end
      calm = (pending_q.size() < CALM_TAIL);
      if (s_axis_tuser == CMD_CLEAR) begin
        stat_count = '0;
        stat_mean  = '0;
        stat_var   = '0;
      end else begin
        stats_q.push_back(welford_update(s_axis_tdata));
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_running_mean_std_dev_core: errors");
      $finish;
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    sample_beat_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (in_gap != 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (gap_armed && !calm) begin
        // idle burst starts once the core is ready again
        if (s_axis_tready) begin
          in_gap    = $urandom_range(0, 6);
          gap_armed = 1'b0;
        end
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].pause_first && stats_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.sample;
        s_axis_tuser  <= nxt.cmd;
        gap_armed = !calm && ($urandom_range(0, 99) < in_idle_pct);
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && out_beats >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_beat(input cmd_e cmd, input logic [DATA_W-1:0] sample,
                           input bit pause_first = 1'b0);
    sample_beat_t b;
    b.cmd         = cmd;
    b.sample      = sample;
    b.pause_first = pause_first;
    pending_q.push_back(b);
  endtask

  initial begin
    int                run_len;
    int                style;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] val;

    // directed: extremes, clears, zero spread, bit patterns
    push_beat(CMD_ACC, 32'h0000_0000);
    push_beat(CMD_ACC, 32'h7FFF_FFFF);
    push_beat(CMD_ACC, 32'h8000_0000);
    push_beat(CMD_ACC, 32'h8000_0000);
    push_beat(CMD_ACC, 32'h7FFF_FFFF);
    push_beat(CMD_CLEAR, 32'hFFFF_FFFF);
    push_beat(CMD_ACC, 32'h8000_0000);
    push_beat(CMD_ACC, 32'h7FFF_FFFF);
    push_beat(CMD_ACC, 32'h8000_0000);
    push_beat(CMD_ACC, 32'h7FFF_FFFF);
    push_beat(CMD_CLEAR, 32'h0000_0000);
    push_beat(CMD_CLEAR, 32'h5555_AAAA);
    push_beat(CMD_ACC, 32'h0000_0001);
    push_beat(CMD_ACC, 32'hFFFF_FFFF);
    push_beat(CMD_ACC, 32'h0001_0000);
    push_beat(CMD_ACC, 32'hFFFF_0000);
    push_beat(CMD_CLEAR, 32'h0000_0000, 1'b1);
    push_beat(CMD_ACC, 32'h0000_3039);
    push_beat(CMD_ACC, 32'h0000_3039);
    push_beat(CMD_ACC, 32'h0000_3039);
    push_beat(CMD_ACC, 32'h5555_AAAA);
    push_beat(CMD_ACC, 32'hAAAA_5555);
    push_beat(CMD_CLEAR, 32'h0000_0000);

    // random runs of samples, each ended by a clear
    while (pending_q.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       run_len = $urandom_range(1, 3);
        1, 2:    run_len = $urandom_range(41, 300);
        default: run_len = $urandom_range(4, 40);
      endcase
      style = $urandom_range(0, 4);
      base  = $urandom();
      for (int k = 0; k < run_len; k++) begin
        case (style)
          0: val = $urandom();
          1: val = $urandom_range(0, 511) - 256;
          2: val = base + $urandom_range(0, 8191) - 4096;
          3: begin
            case ($urandom_range(0, 4))
              0: val = 32'h8000_0000;
              1: val = 32'h7FFF_FFFF;
              2: val = 32'h0000_0000;
              3: val = 32'hFFFF_FFFF;
              default: val = 32'h0000_0001;
            endcase
          end
          default: val = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        endcase
        if ($urandom_range(0, 99) < 3) begin
          push_beat(CMD_CLEAR, $urandom());
        end
        push_beat(CMD_ACC, val, $urandom_range(0, 99) == 0);
      end
      push_beat(CMD_CLEAR, $urandom());
    end
    pending_q[pending_q.size() / 2].pause_first = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid || stats_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_running_mean_std_dev_core: clean");
    end else begin
      $display("tb_running_mean_std_dev_core: errors");
    end
    $finish;
  end

endmodule
